/* rtl/ipof_pkg.sv */
// Shared types, widths and helpers for the impedance position offset filter.
package ipof_pkg;

	localparam int EW   = 32;
	localparam int PW   = 48;
	localparam int CFW  = 32;
	localparam int CW   = 46;
	localparam int ESW  = 34;
	localparam int NW   = 98;
	localparam int QW   = 47;
	localparam int PRW  = 65;
	localparam int CNTW = 6;

	localparam logic [CNTW-1:0] MUL_LAST = CNTW'(6);
	localparam logic [CNTW-1:0] DIV_LAST = CNTW'(QW - 1);

	localparam logic [CFW-1:0] MASS_RST      = 32'd256;
	localparam logic [CFW-1:0] DAMPING_RST   = 32'd153600;
	localparam logic [CFW-1:0] STIFFNESS_RST = 32'd23040000;

	localparam logic [1:0] REG_MASS      = 2'd0;
	localparam logic [1:0] REG_DAMPING   = 2'd1;
	localparam logic [1:0] REG_STIFFNESS = 2'd2;

	localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COEF,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       coef;
		logic       mul_en;
		logic [2:0] mul_idx;
		logic       acc_en;
		logic       prep;
		logic       div_step;
		logic       finish;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

	function automatic logic signed [PW-1:0] sat48(input logic signed [PW:0] v);
		logic signed [PW-1:0] r;
		if (v[PW] != v[PW-1]) begin
			r = v[PW] ? POS_MIN : POS_MAX;
		end else begin
			r = v[PW-1:0];
		end
		return r;
	endfunction

endpackage

/* rtl/ipof_ctrl.sv */
// Sequencer for the filter: load, coefficients, multiply-accumulate, divide, emit.
module ipof_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ipof_pkg::stat_t stat,
	output ipof_pkg::cmd_t  cmd
);
	import ipof_pkg::*;

	state_t          state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_COEF;
				end
			end
			ST_COEF: begin
				cmd.coef = 1'b1;
				cnt_d    = '0;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en  = (cnt_q != MUL_LAST);
				cmd.mul_idx = cnt_q[2:0];
				cmd.acc_en  = (cnt_q != '0);
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == MUL_LAST) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				cnt_d    = '0;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.coef, cmd.prep, cmd.div_step, cmd.finish, cmd.emit}))
		else $error("ipof_ctrl: overlapping commands");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_COEF)
		else $error("ipof_ctrl: load did not start work");

	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> cnt_q <= MUL_LAST)
		else $error("ipof_ctrl: multiply count out of range");

endmodule

/* rtl/ipof_dp.sv */
// Datapath: coefficients, sliced multiply-accumulate, restoring divider, history and output.
module ipof_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ipof_pkg::cmd_t                    cmd,
	output ipof_pkg::stat_t                   stat,
	input  logic [ipof_pkg::CFW-1:0]          mass,
	input  logic [ipof_pkg::CFW-1:0]          damping,
	input  logic [ipof_pkg::CFW-1:0]          stiffness,
	input  logic signed [ipof_pkg::EW-1:0]    force_error,
	input  logic signed [ipof_pkg::PW-1:0]    planned_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ipof_pkg::PW-1:0]    step_offset,
	output logic signed [ipof_pkg::PW-1:0]    corrected_z
);
	import ipof_pkg::*;

	logic signed [EW-1:0]  e_q, error_prev1_q, error_prev2_q;
	logic signed [PW-1:0]  z_q, offset_prev1_q, offset_prev2_q, offset_sum_q, y_q;
	logic [CW-1:0]         ca_q;
	logic signed [PW-1:0]  cb_q, cc_q;
	logic signed [NW-1:0]  acc_q;
	logic signed [PRW-1:0] prod_s1;
	logic [5:0]            sh_s1;
	logic                  neg_q, sat_q;
	logic [CW-1:0]         rem_q;
	logic [QW-1:0]         quo_q;
	logic                  out_valid_q;
	logic signed [PW-1:0]  step_offset_q, corrected_z_q;

	logic [PW-1:0]         ca_w, cb_w, cc_w;
	logic signed [ESW-1:0] es_w;
	logic signed [PW-1:0]  mc;
	logic signed [16:0]    mk;
	logic [5:0]            sh;
	logic [NW-1:0]         mag;
	logic [CW:0]           rem2;
	logic                  ge;
	logic [CW:0]           rem_sub;
	logic signed [PW-1:0]  y_c;

	assign ca_w = PW'(mass) * PW'(10000) + PW'(damping) * PW'(100) + PW'(stiffness);
	assign cb_w = (PW'(stiffness) << 1) - PW'(mass) * PW'(20000);
	assign cc_w = PW'(mass) * PW'(10000) + PW'(stiffness) - PW'(damping) * PW'(100);
	assign es_w = ESW'(e_q) + (ESW'(error_prev1_q) <<< 1) + ESW'(error_prev2_q);

	always_comb begin
		mc = '0;
		mk = '0;
		sh = '0;
		unique case (cmd.mul_idx)
			3'd0: begin mc = cb_q; mk = {1'b0, offset_prev1_q[15:0]};  sh = 6'd0;  end
			3'd1: begin mc = cb_q; mk = {1'b0, offset_prev1_q[31:16]}; sh = 6'd16; end
			3'd2: begin mc = cb_q; mk = {offset_prev1_q[47], offset_prev1_q[47:32]}; sh = 6'd32; end
			3'd3: begin mc = cc_q; mk = {1'b0, offset_prev2_q[15:0]};  sh = 6'd0;  end
			3'd4: begin mc = cc_q; mk = {1'b0, offset_prev2_q[31:16]}; sh = 6'd16; end
			3'd5: begin mc = cc_q; mk = {offset_prev2_q[47], offset_prev2_q[47:32]}; sh = 6'd32; end
			default: begin mc = '0; mk = '0; sh = '0; end
		endcase
	end

	assign mag     = acc_q[NW-1] ? NW'(-acc_q) : NW'(acc_q);
	assign rem2    = {rem_q, quo_q[QW-1]};
	assign ge      = rem2 >= {1'b0, ca_q};
	assign rem_sub = rem2 - {1'b0, ca_q};

	always_comb begin
		if (ca_q == '0) begin
			y_c = '0;
		end else if (sat_q) begin
			y_c = neg_q ? POS_MIN : POS_MAX;
		end else if (neg_q) begin
			y_c = -$signed({1'b0, quo_q});
		end else begin
			y_c = $signed({1'b0, quo_q});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q <= force_error;
			z_q <= planned_z;
		end
		if (cmd.coef) begin
			ca_q  <= ca_w[CW-1:0];
			cb_q  <= $signed(cb_w);
			cc_q  <= $signed(cc_w);
			acc_q <= NW'(es_w) <<< 32;
		end
		if (cmd.mul_en) begin
			prod_s1 <= mc * mk;
			sh_s1   <= sh;
		end
		if (cmd.acc_en) begin
			acc_q <= acc_q - (NW'(prod_s1) <<< sh_s1);
		end
		if (cmd.prep) begin
			neg_q <= acc_q[NW-1];
			sat_q <= mag[NW-1:QW] >= (NW-QW)'(ca_q);
			rem_q <= mag[QW+CW-1:QW];
			quo_q <= mag[QW-1:0];
		end
		if (cmd.div_step) begin
			rem_q <= ge ? rem_sub[CW-1:0] : rem2[CW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
		if (cmd.finish) begin
			y_q <= y_c;
		end
		if (cmd.emit) begin
			step_offset_q <= y_q;
			corrected_z_q <= sat48((PW+1)'(z_q) + (PW+1)'(offset_sum_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_prev1_q  <= '0;
			error_prev2_q  <= '0;
			offset_prev1_q <= '0;
			offset_prev2_q <= '0;
			offset_sum_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.finish) begin
				error_prev2_q  <= error_prev1_q;
				error_prev1_q  <= e_q;
				offset_prev2_q <= offset_prev1_q;
				offset_prev1_q <= y_c;
				offset_sum_q   <= sat48((PW+1)'(offset_sum_q) + (PW+1)'(y_c));
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign step_offset   = step_offset_q;
	assign corrected_z   = corrected_z_q;

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && !sat_q |-> rem_q < ca_q)
		else $error("ipof_dp: divider remainder not below divisor");

	a_hist_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> offset_prev2_q == $past(offset_prev1_q))
		else $error("ipof_dp: offset history did not shift");

	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && ca_q == '0 |=> offset_prev1_q == '0)
		else $error("ipof_dp: zero divisor gave nonzero offset");

endmodule

/* rtl/impedance_position_offset_filter.sv */
// Top level: register port, sequencer and datapath of the impedance position offset filter.
// Each accepted item runs through the sequencer states in order: ST_COEF forms the
// coefficients, ST_MUL runs the 48x17 sliced multiply-accumulate of the numerator,
// ST_PREP takes its magnitude and checks for overflow, ST_DIV runs the one-bit-per-cycle
// restoring divider, and ST_FIN and ST_OUT update the history and load the output register.
// A new item is taken as soon as the previous result sits in the output register, and not
// before; a result still waiting there holds the sequencer and the input.
module impedance_position_offset_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [3:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [ipof_pkg::EW-1:0]  force_error,
	input  logic signed [ipof_pkg::PW-1:0]  planned_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [ipof_pkg::PW-1:0]  step_offset,
	output logic signed [ipof_pkg::PW-1:0]  corrected_z
);
	import ipof_pkg::*;

	logic [CFW-1:0] mass_q, damping_q, stiffness_q;
	logic [1:0]     reg_idx;
	logic           wr_en;
	cmd_t           cmd;
	stat_t          stat;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q      <= MASS_RST;
			damping_q   <= DAMPING_RST;
			stiffness_q <= STIFFNESS_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MASS:      mass_q      <= pwdata;
				REG_DAMPING:   damping_q   <= pwdata;
				REG_STIFFNESS: stiffness_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MASS:      prdata = mass_q;
			REG_DAMPING:   prdata = damping_q;
			REG_STIFFNESS: prdata = stiffness_q;
			default:       prdata = '0;
		endcase
	end

	ipof_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ipof_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mass        (mass_q),
		.damping     (damping_q),
		.stiffness   (stiffness_q),
		.force_error (force_error),
		.planned_z   (planned_z),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.step_offset (step_offset),
		.corrected_z (corrected_z)
	);

endmodule

/* sim/tb_impedance_position_offset_filter.sv */
// Self-checking testbench for the impedance position offset filter: predictor, driver, monitor.
`timescale 1ns / 1ps

module tb_impedance_position_offset_filter;
	import ipof_pkg::*;

	typedef struct {
		logic signed [EW-1:0] force_err;
		logic signed [PW-1:0] plan_z;
	} tick_t;

	typedef struct {
		logic signed [PW-1:0] offset;
		logic signed [PW-1:0] z_out;
	} pos_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 80;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [EW-1:0] force_error;
	logic signed [PW-1:0] planned_z, step_offset, corrected_z;

	impedance_position_offset_filter dut (.*);

	tick_t tick_queue[$];
	pos_t  position_queue[$];

	logic [CFW-1:0] mass_cfg, damping_cfg, stiffness_cfg;
	logic signed [EW-1:0] err_d1, err_d2;
	logic signed [PW-1:0] ofs_d1, ofs_d2, ofs_sum;

	int failures, items_sent, results_seen, idle_cycles;

	function automatic logic signed [PW-1:0] clamp_q840(input logic signed [127:0] v);
		if (v > 128'sh7FFF_FFFF_FFFF) return POS_MAX;
		if (v < -128'sh8000_0000_0000) return POS_MIN;
		return v[PW-1:0];
	endfunction

	function pos_t step_impedance(input tick_t t);
		logic signed [127:0] m, b, k, ca, cb, cc, es, num, y;
		pos_t r;
		m = $signed({96'd0, mass_cfg});
		b = $signed({96'd0, damping_cfg});
		k = $signed({96'd0, stiffness_cfg});
		ca = 10000 * m + 100 * b + k;
		cb = 2 * k - 20000 * m;
		cc = 10000 * m - 100 * b + k;
		es = 128'(t.force_err) + 2 * 128'(err_d1) + 128'(err_d2);
		y = 0;
		if (ca != 0) begin
			num = (es <<< 32) - cb * 128'(ofs_d1) - cc * 128'(ofs_d2);
			y = num / ca;
		end
		r.offset = clamp_q840(y);
		ofs_d2 = ofs_d1;
		ofs_d1 = r.offset;
		err_d2 = err_d1;
		err_d1 = t.force_err;
		ofs_sum = clamp_q840(128'(ofs_sum) + 128'(r.offset));
		r.z_out = clamp_q840(128'(t.plan_z) + 128'(ofs_sum));
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// sender: bursts and gaps
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			force_error <= '0;
			planned_z <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				position_queue.insert(position_queue.size(),
					step_impedance('{force_error, planned_z}));
				items_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 0;
				end else if (tick_queue.size() > 0) begin
					tick_t t;
					t = tick_queue.pop_front();
					force_error <= t.force_err;
					planned_z <= t.plan_z;
					in_valid <= 1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// receiver: stall pattern plus one long hold-off
	int ready_mode, mode_cycles, hold_left;
	bit hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			ready_mode <= 0;
			mode_cycles <= 0;
			hold_left <= 0;
			hold_done <= 0;
		end else begin
			if (!hold_done && results_seen >= 400) begin
				hold_done <= 1;
				hold_left <= 600;
				out_ready <= 0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 0;
			end else begin
				if (mode_cycles == 0) begin
					ready_mode <= $urandom_range(0, 2);
					mode_cycles <= $urandom_range(20, 200);
				end else begin
					mode_cycles <= mode_cycles - 1;
				end
				case (ready_mode)
					0: out_ready <= 1;
					1: out_ready <= $urandom_range(0, 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (position_queue.size() == 0) begin
				$error("unexpected item: step_offset %0d corrected_z %0d", step_offset, corrected_z);
				failures++;
			end else begin
				pos_t e;
				e = position_queue.pop_front();
				if (step_offset !== e.offset) begin
					$error("step_offset expected %0d actual %0d", e.offset, step_offset);
					failures++;
				end
				if (corrected_z !== e.z_out) begin
					$error("corrected_z expected %0d actual %0d", e.z_out, corrected_z);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("tb_impedance_position_offset_filter NOT OK");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_MASS: mass_cfg = value;
			REG_DAMPING: damping_cfg = value;
			default: stiffness_cfg = value;
		endcase
	endtask

	task automatic set_coeffs(input logic [31:0] m, input logic [31:0] b, input logic [31:0] k);
		write_reg(REG_MASS, m);
		write_reg(REG_DAMPING, b);
		write_reg(REG_STIFFNESS, k);
	endtask

	task automatic drain;
		while (tick_queue.size() > 0 || in_valid || position_queue.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_tick(input logic [31:0] fe, input logic [47:0] pz);
		tick_queue.insert(tick_queue.size(), '{fe, pz});
	endtask

	function automatic logic [31:0] rand_force();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 2 * 65536 * 50)) - 65536 * 50);
			2: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
			default: return 32'($signed($urandom_range(0, 64)) - 32);
		endcase
	endfunction

	function automatic logic [47:0] rand_pos();
		logic [47:0] v;
		v = {16'($urandom()), 32'($urandom())};
		if ($urandom_range(0, 1)) v = {{8{v[40]}}, v[39:0]};
		return v;
	endfunction

	int phase_count;
	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		mass_cfg = MASS_RST; damping_cfg = DAMPING_RST; stiffness_cfg = STIFFNESS_RST;
		err_d1 = 0; err_d2 = 0; ofs_d1 = 0; ofs_d2 = 0; ofs_sum = 0;
		failures = 0; items_sent = 0; results_seen = 0; idle_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;

		// field extremes at reset coefficients
		add_tick(32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
		add_tick(32'h8000_0000, 48'h8000_0000_0000);
		add_tick(32'h0000_0000, 48'h0);
		add_tick(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		add_tick(32'h0000_0001, 48'h1);
		add_tick(32'h0001_0000, 48'h0000_0100_0000);
		drain();

		// all coefficients zero
		set_coeffs(0, 0, 0);
		add_tick(32'h7FFF_FFFF, 48'h1234_5678_9ABC);
		add_tick(32'h8000_0000, 48'h8000_0000_0000);
		add_tick(32'h0000_1000, 48'h7FFF_FFFF_FFFF);
		drain();

		// tiny divisor: offset and running sum saturate both ways
		set_coeffs(1, 0, 0);
		repeat (4) add_tick(32'h7FFF_FFFF, 48'h7FFF_FFFF_0000);
		repeat (8) add_tick(32'h8000_0000, 48'h8000_0000_0000);
		drain();

		// coefficient maxima
		set_coeffs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_tick(32'h7FFF_FFFF, 48'h0);
		add_tick(32'h8000_0000, 48'h7FFF_FFFF_FFFF);
		add_tick(32'h1234_5678, 48'h8000_0000_0000);
		drain();
		phase_count = 4;

		for (int p = 0; p < 9; p++) begin
			case ($urandom_range(0, 4))
				0: set_coeffs(MASS_RST, DAMPING_RST, STIFFNESS_RST);
				1: set_coeffs($urandom(), $urandom(), $urandom());
				2: set_coeffs($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4));
				3: set_coeffs($urandom_range(0, 1 << 16), $urandom_range(0, 1 << 24),
					$urandom_range(0, 1 << 30));
				default: set_coeffs(32'hFFFF_FFFF, 0, $urandom());
			endcase
			repeat (210) add_tick(rand_force(), rand_pos());
			drain();
			phase_count++;
		end

		$display("%0d items over %0d coefficient settings, %0d results checked",
			items_sent, phase_count, results_seen);
		if (failures == 0)
			$display("tb_impedance_position_offset_filter OK");
		else
			$display("tb_impedance_position_offset_filter NOT OK");
		$finish;
	end

endmodule
